/* rtl/core/btpc_pkg.sv */
package btpc_pkg;

    // Datapath width of the pressure formula and of its divider
    localparam int DIV_W = 64;

    typedef enum logic [1:0] {
        CFG_TEMP_CAL   = 2'd0,
        CFG_PRESS_LOW  = 2'd1,
        CFG_PRESS_HIGH = 2'd2,
        CFG_PRESS_NINE = 2'd3
    } btpc_cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_ZERO_DIVISOR = 2'd1,
        STATUS_NEG_PRESSURE = 2'd2
    } btpc_status_t;

    typedef struct packed {
        logic [19:0] temp_adc;
        logic [19:0] press_adc;
    } btpc_in_t;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic signed [31:0] fine_temperature;
        logic [31:0]        press_pascal;
        btpc_status_t       status;
    } btpc_out_t;

    // Temperature results and divisor flag riding along with the division
    typedef struct packed {
        logic signed [31:0] temp_centi;
        logic signed [31:0] temp_fine;
        logic               zero_div;
    } btpc_side_t;

endpackage

/* rtl/core/btpc_sdiv.sv */
module btpc_sdiv (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [btpc_pkg::DIV_W-1:0]   num,
    input  logic [btpc_pkg::DIV_W-1:0]   den,
    input  btpc_pkg::btpc_side_t         side_in,
    output logic                         out_valid,
    output logic [btpc_pkg::DIV_W-1:0]   quot,
    output btpc_pkg::btpc_side_t         side_out
);
    import btpc_pkg::*;

    // Entry stage: take magnitudes and note the quotient sign
    logic [DIV_W-1:0] un_reg;
    logic [DIV_W-1:0] ud_reg;
    logic             neg_reg;
    btpc_side_t       side_reg;
    logic             valid_reg;

    logic [DIV_W-1:0] r_reg    [DIV_W];
    logic [DIV_W-1:0] n_reg    [DIV_W];
    logic [DIV_W-1:0] d_reg    [DIV_W];
    logic             sn_reg   [DIV_W];
    btpc_side_t       sd_reg   [DIV_W];
    logic             sv_reg   [DIV_W];

    logic [DIV_W-1:0] quot_reg;
    btpc_side_t       side_out_reg;
    logic             out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            un_reg   <= num[DIV_W-1] ? (DIV_W'(0) - num) : num;
            ud_reg   <= den[DIV_W-1] ? (DIV_W'(0) - den) : den;
            neg_reg  <= num[DIV_W-1] ^ den[DIV_W-1];
            side_reg <= side_in;
        end
    end

    // One quotient bit per stage, restoring form; quotient shifts into n
    for (genvar g = 0; g < DIV_W; g++)
    begin : g_step
        logic [DIV_W-1:0] r_in;
        logic [DIV_W-1:0] n_in;
        logic [DIV_W-1:0] d_in;
        logic             neg_in;
        btpc_side_t       side_i;
        logic             v_in;
        logic [DIV_W:0]   trial;
        logic [DIV_W-1:0] r_next;
        logic [DIV_W-1:0] n_next;

        if (g == 0)
        begin : g_first
            assign r_in   = '0;
            assign n_in   = un_reg;
            assign d_in   = ud_reg;
            assign neg_in = neg_reg;
            assign side_i = side_reg;
            assign v_in   = valid_reg;
        end
        else
        begin : g_rest
            assign r_in   = r_reg[g-1];
            assign n_in   = n_reg[g-1];
            assign d_in   = d_reg[g-1];
            assign neg_in = sn_reg[g-1];
            assign side_i = sd_reg[g-1];
            assign v_in   = sv_reg[g-1];
        end

        always_comb
        begin
            trial = {r_in, n_in[DIV_W-1]} - {1'b0, d_in};
            if (!trial[DIV_W])
            begin
                r_next = trial[DIV_W-1:0];
                n_next = {n_in[DIV_W-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_in[DIV_W-2:0], n_in[DIV_W-1]};
                n_next = {n_in[DIV_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                sv_reg[g] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[g]  <= r_next;
                n_reg[g]  <= n_next;
                d_reg[g]  <= d_in;
                sn_reg[g] <= neg_in;
                sd_reg[g] <= side_i;
            end
        end
    end

    // Exit stage: restore the sign
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= sv_reg[DIV_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg     <= sn_reg[DIV_W-1] ? (DIV_W'(0) - n_reg[DIV_W-1]) : n_reg[DIV_W-1];
            side_out_reg <= sd_reg[DIV_W-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign quot      = quot_reg;
    assign side_out  = side_out_reg;

endmodule

/* rtl/core/baro_temp_pressure_compensation_top.sv */
// Barometric temperature and pressure compensation, integer 64-bit form.
// Each transfer on the sample channel carries one raw 20-bit temperature and
// one raw 20-bit pressure reading; each yields exactly one transfer on the
// result channel with the temperature in 0.01 degC, the fine temperature, the
// pressure in Pa and a status (ok, zero divisor, negative pressure; pressure
// reads 0 unless ok). Calibration words must be loaded through the cfg port
// while the block is idle; the block does not enforce it. Fully pipelined, it
// takes one sample per cycle unless stalled, and each sample passes 8 stages
// of temperature and pressure polynomial, 66 stages of the bit-per-stage
// signed divider, 3 stages of pressure correction and 1 output register.
// When the result side stalls, a skid register takes one more result; after
// that sample_ready drops and the whole pipeline holds until the skid drains.
module baro_temp_pressure_compensation_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_ready,
    input  btpc_pkg::btpc_in_t sample,
    output logic               result_valid,
    input  logic               result_ready,
    output btpc_pkg::btpc_out_t result,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data
);
    import btpc_pkg::*;

    // ---------------------------------------------------------------
    // Calibration registers
    // ---------------------------------------------------------------
    logic [47:0] temp_cal_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_high_reg;
    logic [15:0] press_nine_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cal_reg   <= '0;
            press_low_reg  <= '0;
            press_high_reg <= '0;
            press_nine_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (btpc_cfg_index_t'(cfg_index))
                CFG_TEMP_CAL:   temp_cal_reg   <= cfg_data[47:0];
                CFG_PRESS_LOW:  press_low_reg  <= cfg_data;
                CFG_PRESS_HIGH: press_high_reg <= cfg_data;
                CFG_PRESS_NINE: press_nine_reg <= cfg_data[15:0];
                default:        temp_cal_reg   <= temp_cal_reg;
            endcase
        end
    end

    logic [15:0]        t1;
    logic signed [15:0] t2, t3;
    logic signed [63:0] p1_x, p2_x, p3_x, p4_x, p5_x, p6_x, p7_x, p8_x, p9_x;

    assign t1   = temp_cal_reg[15:0];
    assign t2   = $signed(temp_cal_reg[31:16]);
    assign t3   = $signed(temp_cal_reg[47:32]);
    assign p1_x = $signed({48'd0, press_low_reg[15:0]});
    assign p2_x = $signed(press_low_reg[31:16]);
    assign p3_x = $signed(press_low_reg[47:32]);
    assign p4_x = $signed(press_low_reg[63:48]);
    assign p5_x = $signed(press_high_reg[15:0]);
    assign p6_x = $signed(press_high_reg[31:16]);
    assign p7_x = $signed(press_high_reg[47:32]);
    assign p8_x = $signed(press_high_reg[63:48]);
    assign p9_x = $signed(press_nine_reg);

    // ---------------------------------------------------------------
    // Pipeline advance: every stage moves together unless the skid is full
    // ---------------------------------------------------------------
    logic en;
    logic skid_valid_reg;
    logic out_valid_reg;

    assign en           = !skid_valid_reg;
    assign sample_ready = en;

    logic [10:0] v_reg;   // stage valid bits, front (S1..S8) and back (Q1..Q3)

    // ---------------------------------------------------------------
    // S1: offsets and the first two temperature products
    // ---------------------------------------------------------------
    logic signed [31:0] a_c, b_c, s1_m1_next, s1_bb_next;
    logic signed [31:0] s1_m1_reg, s1_bb_reg;
    logic [19:0]        s1_rp_reg;

    always_comb
    begin
        a_c        = $signed({15'd0, sample.temp_adc[19:3]} - {15'd0, t1, 1'b0});
        b_c        = $signed({16'd0, sample.temp_adc[19:4]} - {16'd0, t1});
        s1_m1_next = a_c * t2;
        s1_bb_next = b_c * b_c;
    end

    // S2: first temperature term, square times T3
    logic signed [31:0] s2_v1t_reg, s2_m2_reg, s2_m2_next;
    logic [19:0]        s2_rp_reg;

    assign s2_m2_next = (s1_bb_reg >>> 12) * t3;

    // S3: fine temperature and centidegrees
    logic signed [31:0] s3_tf_next, s3_tc_next, s3_tf_reg, s3_tc_reg;
    logic [19:0]        s3_rp_reg;

    always_comb
    begin
        s3_tf_next = s2_v1t_reg + (s2_m2_reg >>> 14);
        s3_tc_next = ((s3_tf_next <<< 2) + s3_tf_next + 32'sd128) >>> 8;
    end

    // S4: var1 = t_fine - 128000, its square and the linear products
    logic signed [32:0] v1_c;
    logic signed [63:0] s4_sq_next, s4_lin5_next, s4_lin2_next;
    logic signed [63:0] s4_sq_reg, s4_lin5_reg, s4_lin2_reg;
    logic signed [31:0] s4_tf_reg, s4_tc_reg;
    logic [19:0]        s4_rp_reg;

    always_comb
    begin
        v1_c         = {s3_tf_reg[31], s3_tf_reg} - 33'sd128000;
        s4_sq_next   = v1_c * v1_c;
        s4_lin5_next = v1_c * p5_x;
        s4_lin2_next = v1_c * p2_x;
    end

    // S5: square times P6 and P3
    logic signed [63:0] s5_v2a_reg, s5_v1a_reg, s5_lin5_reg, s5_lin2_reg;
    logic signed [31:0] s5_tf_reg, s5_tc_reg;
    logic [19:0]        s5_rp_reg;

    // S6: sum the var2 terms and the var1 terms
    logic signed [63:0] s6_v2_next, s6_x_next, s6_v2_reg, s6_x_reg;
    logic signed [31:0] s6_tf_reg, s6_tc_reg;
    logic [19:0]        s6_rp_reg;

    always_comb
    begin
        s6_v2_next = s5_v2a_reg + (s5_lin5_reg <<< 17) + (p4_x <<< 35);
        s6_x_next  = 64'sh0000_8000_0000_0000 + (s5_v1a_reg >>> 8) + (s5_lin2_reg <<< 12);
    end

    // S7: scale by P1, form the numerator base
    logic [20:0]        pd_c;
    logic signed [63:0] s7_y_next, s7_nb_next, s7_y_reg, s7_nb_reg;
    logic signed [31:0] s7_tf_reg, s7_tc_reg;

    always_comb
    begin
        pd_c       = 21'h10_0000 - {1'b0, s6_rp_reg};
        s7_y_next  = s6_x_reg * p1_x;
        s7_nb_next = $signed({43'd0, pd_c} << 31) - s6_v2_reg;
    end

    // S8: divisor, numerator times 3125, zero-divisor flag
    logic signed [63:0] s8_den_next, s8_num_next, s8_den_reg, s8_num_reg;
    btpc_side_t         s8_side_reg;

    always_comb
    begin
        s8_den_next = s7_y_reg >>> 33;
        s8_num_next = s7_nb_reg * 64'sd3125;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_m1_reg  <= s1_m1_next;
            s1_bb_reg  <= s1_bb_next;
            s1_rp_reg  <= sample.press_adc;

            s2_v1t_reg <= s1_m1_reg >>> 11;
            s2_m2_reg  <= s2_m2_next;
            s2_rp_reg  <= s1_rp_reg;

            s3_tf_reg  <= s3_tf_next;
            s3_tc_reg  <= s3_tc_next;
            s3_rp_reg  <= s2_rp_reg;

            s4_sq_reg   <= s4_sq_next;
            s4_lin5_reg <= s4_lin5_next;
            s4_lin2_reg <= s4_lin2_next;
            s4_tf_reg   <= s3_tf_reg;
            s4_tc_reg   <= s3_tc_reg;
            s4_rp_reg   <= s3_rp_reg;

            s5_v2a_reg  <= s4_sq_reg * p6_x;
            s5_v1a_reg  <= s4_sq_reg * p3_x;
            s5_lin5_reg <= s4_lin5_reg;
            s5_lin2_reg <= s4_lin2_reg;
            s5_tf_reg   <= s4_tf_reg;
            s5_tc_reg   <= s4_tc_reg;
            s5_rp_reg   <= s4_rp_reg;

            s6_v2_reg <= s6_v2_next;
            s6_x_reg  <= s6_x_next;
            s6_tf_reg <= s5_tf_reg;
            s6_tc_reg <= s5_tc_reg;
            s6_rp_reg <= s5_rp_reg;

            s7_y_reg  <= s7_y_next;
            s7_nb_reg <= s7_nb_next;
            s7_tf_reg <= s6_tf_reg;
            s7_tc_reg <= s6_tc_reg;

            s8_den_reg            <= s8_den_next;
            s8_num_reg            <= s8_num_next;
            s8_side_reg.temp_centi <= s7_tc_reg;
            s8_side_reg.temp_fine  <= s7_tf_reg;
            s8_side_reg.zero_div   <= (s8_den_next == 64'sd0);
        end
    end

    // ---------------------------------------------------------------
    // Signed division, one quotient bit per stage
    // ---------------------------------------------------------------
    logic             div_valid;
    logic [DIV_W-1:0] div_quot;
    btpc_side_t       div_side;

    btpc_sdiv u_sdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_reg[7]),
        .num       (s8_num_reg),
        .den       (s8_den_reg),
        .side_in   (s8_side_reg),
        .out_valid (div_valid),
        .quot      (div_quot),
        .side_out  (div_side)
    );

    // ---------------------------------------------------------------
    // Q1: p >> 13 times P9, p times P8
    // ---------------------------------------------------------------
    logic signed [63:0] q_c, q13_c;
    logic signed [63:0] q1_p_reg, q1_q13_reg, q1_m_reg, q1_pp8_reg;
    btpc_side_t         q1_side_reg;

    assign q_c   = $signed(div_quot);
    assign q13_c = q_c >>> 13;

    // Q2: low 64 bits of the 64x64 product in 32-bit partials
    logic [63:0]        q2_c0_reg;
    logic [31:0]        q2_c1_reg, q2_c2_reg;
    logic signed [63:0] q2_p_reg, q2_pp8_reg;
    btpc_side_t         q2_side_reg;

    // Q3: var1 and var2 of the correction
    logic [63:0]        prod_c;
    logic signed [63:0] q3_p_reg, q3_v1_reg, q3_v2_reg;
    btpc_side_t         q3_side_reg;

    assign prod_c = q2_c0_reg + {q2_c1_reg + q2_c2_reg, 32'd0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_p_reg    <= q_c;
            q1_q13_reg  <= q13_c;
            q1_m_reg    <= q13_c * p9_x;
            q1_pp8_reg  <= q_c * p8_x;
            q1_side_reg <= div_side;

            q2_c0_reg   <= 64'(q1_m_reg[31:0]) * 64'(q1_q13_reg[31:0]);
            q2_c1_reg   <= q1_m_reg[31:0] * q1_q13_reg[63:32];
            q2_c2_reg   <= q1_m_reg[63:32] * q1_q13_reg[31:0];
            q2_p_reg    <= q1_p_reg;
            q2_pp8_reg  <= q1_pp8_reg;
            q2_side_reg <= q1_side_reg;

            q3_p_reg    <= q2_p_reg;
            q3_v1_reg   <= $signed(prod_c) >>> 25;
            q3_v2_reg   <= q2_pp8_reg >>> 19;
            q3_side_reg <= q2_side_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg[0]    <= sample_valid;
            v_reg[7:1]  <= v_reg[6:0];
            v_reg[8]    <= div_valid;
            v_reg[10:9] <= v_reg[9:8];
        end
    end

    // ---------------------------------------------------------------
    // Final pressure and status
    // ---------------------------------------------------------------
    logic signed [63:0] pf_c;
    btpc_out_t          last_c;

    always_comb
    begin
        pf_c                     = ((q3_p_reg + q3_v1_reg + q3_v2_reg) >>> 8) + (p7_x <<< 4);
        last_c.temperature_centi = q3_side_reg.temp_centi;
        last_c.fine_temperature  = q3_side_reg.temp_fine;
        priority if (q3_side_reg.zero_div)
        begin
            last_c.status       = STATUS_ZERO_DIVISOR;
            last_c.press_pascal = '0;
        end
        else if (pf_c[63])
        begin
            last_c.status       = STATUS_NEG_PRESSURE;
            last_c.press_pascal = '0;
        end
        else
        begin
            last_c.status       = STATUS_OK;
            last_c.press_pascal = pf_c[39:8];
        end
    end

    // ---------------------------------------------------------------
    // Output register and skid: hold a stalled result, park one more
    // ---------------------------------------------------------------
    btpc_out_t out_reg, skid_reg;
    logic      out_take;

    assign out_take = result_ready || !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= v_reg[10];
            end
        end
        else if (en && v_reg[10])
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else
            begin
                out_reg <= last_c;
            end
        end
        else if (en && v_reg[10])
        begin
            skid_reg <= last_c;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while the output register is empty");

    a_skid_drains : assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && result_ready) |=> !skid_valid_reg)
        else $error("skid did not drain after a transfer");

    a_error_zero_pressure : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != STATUS_OK) |-> (out_reg.press_pascal == 32'd0))
        else $error("pressure not cleared on an error status");

endmodule
